FILE: rtl/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// Shared constants, command and status codes and the result word type of the
// software timer bank.
// ----------------------------------------------------------------------------
package stb_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int TIDX_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
  localparam int MAX_RPT    = 8;
  localparam int RPT_W      = 4;

  localparam int CMD_W    = 3;
  localparam int ID_W     = 4;
  localparam int DATA_W   = 32;
  localparam int SLOT_W   = 3;
  localparam int STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_CREATE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ATTACH = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DETACH = 3'd2;
  localparam logic [CMD_W-1:0] CMD_START  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NULL_HDL    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RUNNING     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_RUNNING = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NO_FREE     = 3'd5;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
    logic                last;
  } res_t;

endpackage

FILE: rtl/stb_ram.sv
// ----------------------------------------------------------------------------
// stb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module stb_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/stb_outreg.sv
// ----------------------------------------------------------------------------
// stb_outreg
// Output register of the result channel; takes a new word when empty or
// when the held word leaves in the same cycle.
// ----------------------------------------------------------------------------
module stb_outreg
  import stb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  res_t                push_word,
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                kind,
  output logic [SLOT_W-1:0]   slot,
  output logic [STATUS_W-1:0] status,
  output logic                last
);

  res_t word;

  assign can_push = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      word <= push_word;
    end
  end

  assign kind   = word.kind;
  assign slot   = word.slot;
  assign status = word.status;
  assign last   = word.last;

endmodule

FILE: rtl/software_timer_bank_unit.sv
// ----------------------------------------------------------------------------
// software_timer_bank_unit
// Bank of millisecond timers driven by command words.
//
// Input channel (in_valid/in_ready): one command word per item: create,
// attach, detach, start, stop or tick. Result channel (out_valid/out_ready):
// status words and timer expiry events, with last set on the final word of
// an item. A tick of zero and unknown commands give no word.
// Commands other than tick are taken in S_IDLE; the status word is then
// loaded into the output register from S_CMD once the register has room.
// A tick walks the interval and elapsed RAMs through their registered read
// ports, one timer per cycle while no output stall holds it, and then flushes
// a pending expiry at the end. in_ready is high only between items.
// Reset clears all timers at once through per-entry valid bits; the block
// is ready to take a word as soon as reset is released.
// When the receiver stalls, the output register holds its word; a command
// waits for it, and a tick walk pauses on a second expiry until it drains.
// ----------------------------------------------------------------------------
module software_timer_bank_unit
  import stb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [ID_W-1:0]     timer_id,
  input  logic [DATA_W-1:0]   interval_ms,
  input  logic                handler_present,
  input  logic [DATA_W-1:0]   tick_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                kind,
  output logic [SLOT_W-1:0]   slot,
  output logic [STATUS_W-1:0] status,
  output logic                last
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMD   = 4'b0010,
    S_WALK  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [CMD_W-1:0]  lat_cmd;
  logic [ID_W-1:0]   lat_id;
  logic [DATA_W-1:0] lat_ival;
  logic              lat_hp;
  logic [DATA_W-1:0] lat_tick;

  logic [NUM_TIMERS-1:0] run_flags, hdl_flags, busy_flags, iv_vld, el_vld;

  logic              in_acc;
  logic              id_ok;
  logic [TIDX_W-1:0] id_idx;
  logic              free_found;
  logic [TIDX_W-1:0] free_idx;

  logic              push, can_push;
  res_t              push_word, cmd_word;
  logic              cmd_fire;

  // walk pipeline
  logic [CNT_W-1:0]  rd_cnt;
  logic              issue;
  logic              p_vld;
  logic [TIDX_W-1:0] p_idx;
  logic [DATA_W-1:0] iv_rd, el_rd;
  logic [DATA_W-1:0] iv_cur, el_cur, el_sat, el_new;
  logic [DATA_W:0]   el_sum;
  logic              p_run, expire, emit, stall, walk_done;
  logic              have_pend;
  logic [TIDX_W-1:0] pend_idx;
  logic [RPT_W-1:0]  rpt_cnt;
  logic              iv_wr;

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      lat_cmd  <= cmd;
      lat_id   <= timer_id;
      lat_ival <= interval_ms;
      lat_hp   <= handler_present;
      lat_tick <= tick_count;
    end
  end

  assign id_ok  = 32'(lat_id) < NUM_TIMERS;
  assign id_idx = TIDX_W'(lat_id);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!busy_flags[i]) begin
        free_found = 1'b1;
        free_idx   = TIDX_W'(i);
      end
    end
  end

  always_comb begin
    cmd_word        = '0;
    cmd_word.kind   = KIND_STATUS;
    cmd_word.last   = 1'b1;
    cmd_word.status = ST_OK;
    unique case (lat_cmd)
      CMD_CREATE: begin
        if (free_found) begin
          cmd_word.slot = SLOT_W'(free_idx);
        end else begin
          cmd_word.status = ST_NO_FREE;
        end
      end
      CMD_ATTACH: begin
        if (!id_ok) begin
          cmd_word.status = ST_INVALID;
        end else if (!lat_hp) begin
          cmd_word.status = ST_NULL_HDL;
        end
      end
      CMD_DETACH: begin
        if (!id_ok) begin
          cmd_word.status = ST_INVALID;
        end
      end
      CMD_START: begin
        if (!id_ok) begin
          cmd_word.status = ST_INVALID;
        end else if (run_flags[id_idx]) begin
          cmd_word.status = ST_RUNNING;
        end
      end
      CMD_STOP: begin
        if (!id_ok) begin
          cmd_word.status = ST_INVALID;
        end else if (!run_flags[id_idx]) begin
          cmd_word.status = ST_NOT_RUNNING;
        end
      end
      default: begin
        cmd_word.status = ST_OK;
      end
    endcase
  end

  assign cmd_fire = (state == S_CMD) && can_push;
  assign iv_wr    = cmd_fire && (lat_cmd == CMD_CREATE) && free_found;

  // ---------------------------------------------------------------- tick walk
  assign walk_done = (state == S_WALK) && !p_vld && (rd_cnt == CNT_W'(NUM_TIMERS));

  assign iv_cur = iv_vld[p_idx] ? iv_rd : '0;
  assign el_cur = el_vld[p_idx] ? el_rd : '0;
  assign el_sum = {1'b0, el_cur} + {1'b0, lat_tick};
  assign el_sat = el_sum[DATA_W] ? '1 : el_sum[DATA_W-1:0];
  assign p_run  = run_flags[p_idx];
  assign expire = (iv_cur != '0) && (el_sat >= iv_cur);
  assign el_new = expire ? '0 : el_sat;
  assign emit   = p_vld && p_run && expire && hdl_flags[p_idx]
                  && (rpt_cnt < RPT_W'(MAX_RPT));
  assign stall  = emit && have_pend && !can_push;
  assign issue  = (state == S_WALK) && !stall && (rd_cnt < CNT_W'(NUM_TIMERS));

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld     <= 1'b0;
      have_pend <= 1'b0;
      rd_cnt    <= '0;
      rpt_cnt   <= '0;
    end else if (in_acc) begin
      p_vld     <= 1'b0;
      have_pend <= 1'b0;
      rd_cnt    <= '0;
      rpt_cnt   <= '0;
    end else begin
      if (!stall) begin
        p_vld <= issue;
        if (issue) begin
          rd_cnt <= rd_cnt + 1'b1;
        end
        if (emit) begin
          have_pend <= 1'b1;
          rpt_cnt   <= rpt_cnt + 1'b1;
        end
      end
      if (state == S_FLUSH && can_push) begin
        have_pend <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      p_idx <= rd_cnt[TIDX_W-1:0];
    end
    if (emit && !stall) begin
      pend_idx <= p_idx;
    end
  end

  stb_ram #(.DEPTH(NUM_TIMERS), .WIDTH(DATA_W)) u_iv_ram (
    .clk     (clk),
    .wr_en   (iv_wr),
    .wr_addr (free_idx),
    .wr_data (lat_ival),
    .rd_en   (issue),
    .rd_addr (rd_cnt[TIDX_W-1:0]),
    .rd_data (iv_rd)
  );

  stb_ram #(.DEPTH(NUM_TIMERS), .WIDTH(DATA_W)) u_el_ram (
    .clk     (clk),
    .wr_en   (p_vld && !stall && p_run),
    .wr_addr (p_idx),
    .wr_data (el_new),
    .rd_en   (issue),
    .rd_addr (rd_cnt[TIDX_W-1:0]),
    .rd_data (el_rd)
  );

  // ----------------------------------------------------------------- flags
  always_ff @(posedge clk) begin
    if (rst) begin
      run_flags  <= '0;
      hdl_flags  <= '0;
      busy_flags <= '0;
      iv_vld     <= '0;
      el_vld     <= '0;
    end else begin
      if (p_vld && !stall && p_run) begin
        el_vld[p_idx] <= 1'b1;
      end
      if (iv_wr) begin
        iv_vld[free_idx]     <= 1'b1;
        busy_flags[free_idx] <= (lat_ival != '0);
        el_vld[free_idx]     <= 1'b0;
      end
      if (cmd_fire && id_ok) begin
        unique case (lat_cmd)
          CMD_ATTACH: begin
            if (lat_hp) begin
              hdl_flags[id_idx] <= 1'b1;
            end
          end
          CMD_DETACH: begin
            hdl_flags[id_idx] <= 1'b0;
          end
          CMD_START: begin
            if (!run_flags[id_idx]) begin
              run_flags[id_idx] <= 1'b1;
              el_vld[id_idx]    <= 1'b0;
            end
          end
          CMD_STOP: begin
            run_flags[id_idx] <= 1'b0;
          end
          default: begin
            run_flags <= run_flags;
          end
        endcase
      end
    end
  end

  // ------------------------------------------------------------ result push
  always_comb begin
    push_word = cmd_word;
    push      = 1'b0;
    if (state == S_CMD) begin
      push = can_push;
    end else if (state == S_WALK) begin
      push             = emit && have_pend && can_push;
      push_word        = '0;
      push_word.kind   = KIND_EXPIRY;
      push_word.slot   = SLOT_W'(pend_idx);
      push_word.status = ST_OK;
      push_word.last   = 1'b0;
    end else if (state == S_FLUSH) begin
      push             = can_push;
      push_word        = '0;
      push_word.kind   = KIND_EXPIRY;
      push_word.slot   = SLOT_W'(pend_idx);
      push_word.status = ST_OK;
      push_word.last   = 1'b1;
    end
  end

  stb_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .slot      (slot),
    .status    (status),
    .last      (last)
  );

  // ------------------------------------------------------------ sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          case (cmd) inside
            CMD_CREATE, CMD_ATTACH, CMD_DETACH, CMD_START, CMD_STOP: begin
              state_next = S_CMD;
            end
            CMD_TICK: begin
              if (tick_count != '0) begin
                state_next = S_WALK;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_CMD: begin
        if (can_push) begin
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        if (walk_done) begin
          state_next = have_pend ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        if (can_push) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> can_push)
    else $error("result pushed into a full output register");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    stall |=> p_vld && $stable(p_idx) && $stable(rd_cnt))
    else $error("walk advanced through a stall");

  a_pend_scope: assert property (@(posedge clk) disable iff (rst)
    have_pend |-> (state == S_WALK || state == S_FLUSH))
    else $error("pending expiry outside a tick");

  a_rpt_bound: assert property (@(posedge clk) disable iff (rst)
    rpt_cnt <= RPT_W'(MAX_RPT))
    else $error("more expiries reported than allowed");
`endif

endmodule

FILE: tb/tb_software_timer_bank_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_software_timer_bank_unit
// Self-checking bench for the software timer bank. A behavioral copy of the
// timer bank runs beside the block, and each result word is checked in order
// against it. Directed checks come first, then a long-stall pass, then random
// command traffic under three idling patterns.
// ----------------------------------------------------------------------------
module tb_software_timer_bank_unit;
  import stb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_B = 3'd7;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = NUM_TIMERS + 6;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    cmd = CMD_UNUSED_A;
  logic [ID_W-1:0]     timer_id = '0;
  logic [DATA_W-1:0]   interval_ms = '0;
  logic                handler_present = 1'b0;
  logic [DATA_W-1:0]   tick_count = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                kind;
  logic [SLOT_W-1:0]   slot;
  logic [STATUS_W-1:0] status;
  logic                last;

  // copy of the timer bank state
  logic [DATA_W-1:0] tmr_interval [NUM_TIMERS];
  logic [DATA_W-1:0] tmr_elapsed  [NUM_TIMERS];
  logic              tmr_running  [NUM_TIMERS];
  logic              tmr_handler  [NUM_TIMERS];

  res_t status_expiry_q [$];
  res_t want_word;

  int tx_idle_pct = 7;
  int rx_idle_pct = 72;
  int hold_req    = 0;
  int hold_left   = 0;
  int stall_cnt   = 0;
  int fail_cnt    = 0;
  int words_sent  = 0;
  int words_seen  = 0;
  int expiry_seen = 0;
  int most_expiry = 0;

  software_timer_bank_unit uut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .cmd             (cmd),
    .timer_id        (timer_id),
    .interval_ms     (interval_ms),
    .handler_present (handler_present),
    .tick_count      (tick_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .slot            (slot),
    .status          (status),
    .last            (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic res_t make_word(logic k, logic [SLOT_W-1:0] s,
                                     logic [STATUS_W-1:0] st, logic l);
    res_t w;
    w.kind   = k;
    w.slot   = s;
    w.status = st;
    w.last   = l;
    return w;
  endfunction

  // Advance the bank copy by one command word and queue the words it causes.
  function automatic void timer_bank_update(logic [CMD_W-1:0] c, logic [ID_W-1:0] id,
                                            logic [DATA_W-1:0] ival, logic hp,
                                            logic [DATA_W-1:0] n);
    res_t                expiries [$];
    res_t                w;
    logic [STATUS_W-1:0] st;
    logic [DATA_W:0]     sum;
    logic [DATA_W-1:0]   e;
    logic                id_ok;
    logic [TIDX_W-1:0]   ix;
    int                  found;
    id_ok = (id < NUM_TIMERS);
    ix    = id[TIDX_W-1:0];
    st    = ST_OK;
    found = -1;
    case (c)
      CMD_CREATE: begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (found < 0 && tmr_interval[i] == '0) found = i;
        end
        if (found >= 0) begin
          tmr_interval[found] = ival;
          tmr_elapsed[found]  = '0;
          status_expiry_q.push_back(make_word(KIND_STATUS, found[SLOT_W-1:0], ST_OK, 1'b1));
        end else begin
          status_expiry_q.push_back(make_word(KIND_STATUS, '0, ST_NO_FREE, 1'b1));
        end
      end
      CMD_ATTACH: begin
        if (!id_ok) st = ST_INVALID;
        else if (!hp) st = ST_NULL_HDL;
        else tmr_handler[ix] = 1'b1;
        status_expiry_q.push_back(make_word(KIND_STATUS, '0, st, 1'b1));
      end
      CMD_DETACH: begin
        if (!id_ok) st = ST_INVALID;
        else tmr_handler[ix] = 1'b0;
        status_expiry_q.push_back(make_word(KIND_STATUS, '0, st, 1'b1));
      end
      CMD_START: begin
        if (!id_ok) st = ST_INVALID;
        else if (tmr_running[ix]) st = ST_RUNNING;
        else begin
          tmr_running[ix] = 1'b1;
          tmr_elapsed[ix] = '0;
        end
        status_expiry_q.push_back(make_word(KIND_STATUS, '0, st, 1'b1));
      end
      CMD_STOP: begin
        if (!id_ok) st = ST_INVALID;
        else if (!tmr_running[ix]) st = ST_NOT_RUNNING;
        else tmr_running[ix] = 1'b0;
        status_expiry_q.push_back(make_word(KIND_STATUS, '0, st, 1'b1));
      end
      CMD_TICK: begin
        if (n != '0) begin
          for (int i = 0; i < NUM_TIMERS; i++) begin
            if (tmr_running[i]) begin
              sum = {1'b0, tmr_elapsed[i]} + {1'b0, n};
              e   = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
              tmr_elapsed[i] = e;
              if (tmr_interval[i] != '0 && e >= tmr_interval[i]) begin
                tmr_elapsed[i] = '0;
                if (tmr_handler[i] && expiries.size() < MAX_RPT)
                  expiries.push_back(make_word(KIND_EXPIRY, i[SLOT_W-1:0], ST_OK, 1'b0));
              end
            end
          end
          if (expiries.size() > most_expiry) most_expiry = expiries.size();
          for (int i = 0; i < expiries.size(); i++) begin
            w = expiries[i];
            if (i == expiries.size() - 1) w.last = 1'b1;
            status_expiry_q.push_back(w);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Offer one command word and wait for the block to take it.
  task automatic send_word(logic [CMD_W-1:0] c, logic [ID_W-1:0] id,
                           logic [DATA_W-1:0] ival, logic hp, logic [DATA_W-1:0] n);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    cmd             <= c;
    timer_id        <= id;
    interval_ms     <= ival;
    handler_present <= hp;
    tick_count      <= n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
    timer_bank_update(c, id, ival, hp, n);
  endtask

  // Drop valid and wait until every queued word has come out.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (status_expiry_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Receiver side: random stalls, or a long hold when one is requested.
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      words_seen++;
      if (kind == KIND_EXPIRY) expiry_seen++;
      if (status_expiry_q.size() == 0) begin
        $error("word with nothing pending: kind=%0d slot=%0d status=%0d last=%0d",
               kind, slot, status, last);
        fail_cnt++;
      end else begin
        want_word = status_expiry_q.pop_front();
        if (kind !== want_word.kind) begin
          $error("kind: expected %0d, actual %0d", want_word.kind, kind);
          fail_cnt++;
        end
        if (slot !== want_word.slot) begin
          $error("slot: expected %0d, actual %0d", want_word.slot, slot);
          fail_cnt++;
        end
        if (status !== want_word.status) begin
          $error("status: expected %0d, actual %0d", want_word.status, status);
          fail_cnt++;
        end
        if (last !== want_word.last) begin
          $error("last: expected %0d, actual %0d", want_word.last, last);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog: cycles with no handshake on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic test_create_and_full;
    send_word(CMD_CREATE, 4'd0, 32'd0, 1'b0, 32'd0);      // slot 0 still looks free
    send_word(CMD_CREATE, 4'd0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_word(CMD_CREATE, 4'd0, 32'd1, 1'b0, 32'd0);
    send_word(CMD_CREATE, 4'd0, 32'd2, 1'b0, 32'd0);
    send_word(CMD_CREATE, 4'd0, 32'd3, 1'b0, 32'd0);
    send_word(CMD_CREATE, 4'd0, 32'd4, 1'b0, 32'd0);
    send_word(CMD_CREATE, 4'd0, 32'd5, 1'b0, 32'd0);
    send_word(CMD_CREATE, 4'd0, 32'd8, 1'b0, 32'd0);
    send_word(CMD_CREATE, 4'd0, 32'd13, 1'b0, 32'd0);
    send_word(CMD_CREATE, 4'd0, 32'h1234_5678, 1'b0, 32'd0); // bank full
  endtask

  task automatic test_command_errors;
    send_word(CMD_ATTACH, 4'd15, 32'd0, 1'b1, 32'd0);
    send_word(CMD_ATTACH, 4'd1, 32'd0, 1'b0, 32'd0);
    send_word(CMD_ATTACH, 4'd0, 32'd0, 1'b1, 32'd0);
    send_word(CMD_DETACH, 4'd9, 32'd0, 1'b0, 32'd0);
    send_word(CMD_START, 4'd0, 32'd0, 1'b0, 32'd0);
    send_word(CMD_START, 4'd0, 32'd0, 1'b0, 32'd0);
    send_word(CMD_STOP, 4'd12, 32'd0, 1'b0, 32'd0);
    send_word(CMD_STOP, 4'd2, 32'd0, 1'b0, 32'd0);
    send_word(CMD_TICK, 4'd0, 32'd0, 1'b0, 32'd0);
    send_word(CMD_UNUSED_A, 4'd3, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    send_word(CMD_UNUSED_B, 4'd7, 32'd0, 1'b0, 32'd7);
  endtask

  task automatic test_tick_expiry;
    send_word(CMD_START, 4'd1, 32'd0, 1'b0, 32'd0);
    send_word(CMD_TICK, 4'd0, 32'd0, 1'b0, 32'd1);            // expiry without handler
    send_word(CMD_TICK, 4'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);    // saturate slot 0
    send_word(CMD_STOP, 4'd0, 32'd0, 1'b0, 32'd0);
    drain();
  endtask

  task automatic test_backpressure;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < NUM_TIMERS; i++)
      send_word(CMD_ATTACH, i[ID_W-1:0], 32'd0, 1'b1, 32'd0);
    for (int i = 0; i < NUM_TIMERS; i++)
      send_word(CMD_START, i[ID_W-1:0], 32'd0, 1'b0, 32'd0);
    drain();
    @(posedge clk);
    hold_req = HOLD_CYCLES;
    // every timer expires at once while the receiver holds off
    send_word(CMD_TICK, 4'd0, 32'd0, 1'b0, 32'hFFFF_FFFF);
    send_word(CMD_START, 4'd3, 32'd0, 1'b0, 32'd0);
    send_word(CMD_TICK, 4'd0, 32'd0, 1'b0, 32'd40);
    send_word(CMD_STOP, 4'd4, 32'd0, 1'b0, 32'd0);
    send_word(CMD_START, 4'd4, 32'd0, 1'b0, 32'd0);
    drain();
  endtask

  task automatic test_random_traffic(int tx_pct, int rx_pct, int n_words);
    logic [CMD_W-1:0]  c;
    logic [ID_W-1:0]   id;
    logic [DATA_W-1:0] ival;
    logic [DATA_W-1:0] n;
    logic              hp;
    int                r;
    int                done;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    done = 0;
    while (done < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 4) c = CMD_CREATE;
      else if (r < 20) c = CMD_ATTACH;
      else if (r < 28) c = CMD_DETACH;
      else if (r < 44) c = CMD_START;
      else if (r < 58) c = CMD_STOP;
      else if (r < 96) c = CMD_TICK;
      else c = $urandom_range(0, 1) ? CMD_UNUSED_A : CMD_UNUSED_B;
      id   = ($urandom_range(0, 99) < 88) ? ID_W'($urandom_range(0, NUM_TIMERS - 1))
                                          : ID_W'($urandom_range(NUM_TIMERS, 15));
      hp   = ($urandom_range(0, 99) < 80);
      ival = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 40) : $urandom;
      r    = $urandom_range(0, 99);
      if (r < 8) n = '0;
      else if (r < 82) n = $urandom_range(1, 12);
      else n = $urandom;
      send_word(c, id, ival, hp, n);
      if (c <= CMD_TICK && !(c == CMD_TICK && n == '0)) done++;
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      tmr_interval[i] = '0;
      tmr_elapsed[i]  = '0;
      tmr_running[i]  = 1'b0;
      tmr_handler[i]  = 1'b0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_create_and_full();
    test_command_errors();
    test_tick_expiry();
    test_backpressure();
    test_random_traffic(7, 72, 120);
    test_random_traffic(72, 7, 120);
    test_random_traffic(0, 0, 120);

    $display("tb: %0d command words sent, %0d result words checked, %0d of them expiries",
             words_sent, words_seen, expiry_seen);
    $display("tb: up to %0d expiries from one tick, with a %0d-cycle receiver hold",
             most_expiry, HOLD_CYCLES);
    if (fail_cnt == 0 && status_expiry_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
